FILE: rtl/core/qct_pkg.sv
// ----------------------------------------------------------------------------
// qct_pkg
// Types and constants that the tokenizer's front, queue and back share.
// ----------------------------------------------------------------------------
package qct_pkg;

	localparam int CHAR_W      = 8;
	localparam int NUM_W       = 8;
	localparam int LEN_W       = 12;
	localparam int MAX_RESULTS = 4;
	localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int CFG_IDX_W   = 1;

	localparam int LEN_FIELD_MAX = (1 << LEN_W) - 1;
	localparam int NUM_FIELD_MAX = (1 << NUM_W) - 1;

	localparam int DEF_MAX_LINE_CHARS = 4095;
	localparam int DEF_MAX_TOKENS     = 255;
	localparam int DEF_QUEUE_DEPTH    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM  = 1'b1;

	localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd32;
	localparam logic              NORM_RESET  = 1'b1;

	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_TOKEN = 2'd1,
		KIND_LINE  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] ch;
		logic [NUM_W-1:0]  num;
		logic [LEN_W-1:0]  len;
		logic              st;
		logic [LEN_W-1:0]  pos;
	} res_t;

	typedef struct packed {
		res_t [MAX_RESULTS-1:0] res;
		logic [RES_CNT_W-1:0]   n;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t head;
	} q_head_t;

endpackage

FILE: rtl/core/qct_front.sv
// ----------------------------------------------------------------------------
// qct_front
// Accepts line bytes, applies the whitespace front stage when enabled and the
// tokenizer rules, and pushes any results of a byte as one queue bundle.
// ----------------------------------------------------------------------------
module qct_front #(
	parameter int MAX_LINE_CHARS = qct_pkg::DEF_MAX_LINE_CHARS,
	parameter int MAX_TOKENS     = qct_pkg::DEF_MAX_TOKENS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [qct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qct_pkg::CHAR_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [qct_pkg::CHAR_W-1:0]     line_byte,
	input  logic                           line_last,
	input  logic                           q_full,
	output logic                           push,
	output qct_pkg::bundle_t               push_bundle
);

	localparam int CharCapI = (MAX_LINE_CHARS < qct_pkg::LEN_FIELD_MAX) ?
		MAX_LINE_CHARS : qct_pkg::LEN_FIELD_MAX;
	localparam int TokCapI = (MAX_TOKENS < qct_pkg::NUM_FIELD_MAX) ?
		MAX_TOKENS : qct_pkg::NUM_FIELD_MAX;
	localparam logic [qct_pkg::LEN_W-1:0] CharCap = qct_pkg::LEN_W'(CharCapI);
	localparam logic [qct_pkg::NUM_W-1:0] TokCap  = qct_pkg::NUM_W'(TokCapI);

	typedef struct packed {
		logic                       in_quote;
		logic                       esc;
		logic                       comment;
		logic [qct_pkg::LEN_W-1:0]  len;
		logic [qct_pkg::NUM_W-1:0]  count;
		logic [qct_pkg::LEN_W-1:0]  chars;
	} tok_state_t;

	typedef struct packed {
		tok_state_t     st;
		logic           emit;
		qct_pkg::res_t  res;
	} tk_out_t;

	function automatic tk_out_t complete_tok(tok_state_t s);
		tk_out_t o;
		o = '0;
		o.st = s;
		o.emit = 1'b1;
		o.res.kind = qct_pkg::KIND_TOKEN;
		o.res.num = s.count;
		o.res.len = s.len;
		if (s.count < TokCap) begin
			o.st.count = s.count + 1'b1;
		end
		o.st.len = '0;
		return o;
	endfunction

	function automatic tk_out_t append_ch(tok_state_t s, logic [qct_pkg::CHAR_W-1:0] c);
		tk_out_t o;
		o = '0;
		o.st = s;
		o.emit = 1'b1;
		o.res.kind = qct_pkg::KIND_CHAR;
		o.res.ch = c;
		o.res.num = s.count;
		if (s.len < CharCap) begin
			o.st.len = s.len + 1'b1;
		end
		o.st.esc = 1'b0;
		return o;
	endfunction

	function automatic tk_out_t tokenize(tok_state_t s, logic [qct_pkg::CHAR_W-1:0] c,
			logic [qct_pkg::CHAR_W-1:0] delim);
		tk_out_t o;
		tok_state_t t;
		o = '0;
		o.st = s;
		t = s;
		if (!s.comment) begin
			if (s.chars < CharCap) begin
				t.chars = s.chars + 1'b1;
			end
			o.st = t;
			if (s.in_quote) begin
				if (c == qct_pkg::CH_BSLASH) begin
					if (s.esc) begin
						o = append_ch(t, c);
					end else begin
						o.st.esc = 1'b1;
					end
				end else if (c == qct_pkg::CH_QUOTE) begin
					if (s.esc) begin
						o = append_ch(t, c);
					end else begin
						o.st.in_quote = 1'b0;
					end
				end else begin
					o = append_ch(t, c);
				end
			end else if (c == qct_pkg::CH_QUOTE) begin
				o.st.in_quote = 1'b1;
			end else if (c == qct_pkg::CH_HASH) begin
				o.st.comment = 1'b1;
			end else if (c == delim) begin
				o = complete_tok(t);
			end else begin
				o = append_ch(t, c);
			end
		end
		return o;
	endfunction

	logic [qct_pkg::CHAR_W-1:0] delim_q;
	logic                       norm_q;
	tok_state_t                 tok_q;
	logic                       pend_q;
	logic                       seen_q;

	tok_state_t                 tok_d;
	logic                       pend_d;
	logic                       seen_d;
	qct_pkg::bundle_t           bundle;
	logic                       accept;

	always_comb begin
		tk_out_t                       t;
		tok_state_t                    s;
		logic                          ws;
		logic [qct_pkg::RES_CNT_W-1:0] n;
		t = '0;
		s = tok_q;
		n = '0;
		bundle = '0;
		pend_d = pend_q;
		seen_d = seen_q;
		ws = (line_byte == qct_pkg::CH_SPACE) || (line_byte == qct_pkg::CH_TAB) ||
			(line_byte == qct_pkg::CH_CR) || (line_byte == qct_pkg::CH_LF);
		if (norm_q) begin
			if (ws) begin
				if (seen_q) begin
					pend_d = 1'b1;
				end
			end else begin
				if (pend_q) begin
					t = tokenize(s, qct_pkg::CH_SPACE, delim_q);
					s = t.st;
					if (t.emit) begin
						bundle.res[n[qct_pkg::RES_IDX_W-1:0]] = t.res;
						n = n + 1'b1;
					end
				end
				pend_d = 1'b0;
				seen_d = 1'b1;
				t = tokenize(s, line_byte, delim_q);
				s = t.st;
				if (t.emit) begin
					bundle.res[n[qct_pkg::RES_IDX_W-1:0]] = t.res;
					n = n + 1'b1;
				end
			end
		end else begin
			t = tokenize(s, line_byte, delim_q);
			s = t.st;
			if (t.emit) begin
				bundle.res[n[qct_pkg::RES_IDX_W-1:0]] = t.res;
				n = n + 1'b1;
			end
		end
		if (line_last) begin
			if (s.len != '0) begin
				t = complete_tok(s);
				s = t.st;
				bundle.res[n[qct_pkg::RES_IDX_W-1:0]] = t.res;
				n = n + 1'b1;
			end
			bundle.res[n[qct_pkg::RES_IDX_W-1:0]].kind = qct_pkg::KIND_LINE;
			bundle.res[n[qct_pkg::RES_IDX_W-1:0]].num = s.count;
			bundle.res[n[qct_pkg::RES_IDX_W-1:0]].st = s.in_quote;
			bundle.res[n[qct_pkg::RES_IDX_W-1:0]].pos = s.in_quote ? s.chars : '0;
			n = n + 1'b1;
			s = '0;
			pend_d = 1'b0;
			seen_d = 1'b0;
		end
		bundle.n = n;
		tok_d = s;
	end

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign push = accept && (bundle.n != '0);
	assign push_bundle = bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= qct_pkg::DELIM_RESET;
			norm_q <= qct_pkg::NORM_RESET;
			tok_q <= '0;
			pend_q <= 1'b0;
			seen_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					qct_pkg::CFG_DELIM: delim_q <= cfg_data;
					qct_pkg::CFG_NORM: norm_q <= cfg_data[0];
				endcase
			end
			if (accept) begin
				tok_q <= tok_d;
				pend_q <= pend_d;
				seen_q <= seen_d;
			end
		end
	end

endmodule

FILE: rtl/core/qct_queue.sv
// ----------------------------------------------------------------------------
// qct_queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module qct_queue #(
	parameter int QUEUE_DEPTH = qct_pkg::DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qct_pkg::bundle_t push_bundle,
	output logic             full,
	input  logic             pop,
	output qct_pkg::q_head_t head
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] Depth   = CntW'(QUEUE_DEPTH);

	qct_pkg::bundle_t  store_q [QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full = (count_q == Depth);
	assign head.valid = (count_q != '0);
	assign head.head = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/qct_back.sv
// ----------------------------------------------------------------------------
// qct_back
// Hands out the results of the bundle at the head of the queue, one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module qct_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qct_pkg::q_head_t            head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  result_kind,
	output logic [qct_pkg::CHAR_W-1:0]  token_char,
	output logic [qct_pkg::NUM_W-1:0]   token_number,
	output logic [qct_pkg::LEN_W-1:0]   token_length,
	output logic                        line_status,
	output logic [qct_pkg::LEN_W-1:0]   error_position,
	output logic                        result_last
);

	logic [qct_pkg::RES_IDX_W-1:0] idx_q;
	qct_pkg::res_t                 cur;
	logic                          is_last;
	logic                          take;

	assign cur = head.head.res[idx_q];
	assign is_last = ({1'b0, idx_q} + 1'b1) == head.head.n;
	assign out_valid = head.valid;
	assign take = out_valid && out_ready;
	assign pop = take && is_last;

	assign result_kind = cur.kind;
	assign token_char = cur.ch;
	assign token_number = cur.num;
	assign token_length = cur.len;
	assign line_status = cur.st;
	assign error_position = cur.pos;
	assign result_last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= is_last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

FILE: rtl/core/quoted_command_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_command_tokenizer
// Streaming shell-style tokenizer for one command line at a time.
// ----------------------------------------------------------------------------
// The block takes one line byte per cycle while the queue has room and gives
// one result per cycle while out_ready is high. A byte is classified in the
// cycle it is accepted; its results, up to four, go as one bundle into a
// queue of QUEUE_DEPTH entries and leave it one per cycle. A byte that causes
// no result leaves nothing in the queue, so input runs at one byte per cycle
// while the results keep pace, and the output port sets the sustained figure.
module quoted_command_tokenizer #(
	parameter int MAX_LINE_CHARS = qct_pkg::DEF_MAX_LINE_CHARS,
	parameter int MAX_TOKENS     = qct_pkg::DEF_MAX_TOKENS,
	parameter int QUEUE_DEPTH    = qct_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [qct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qct_pkg::CHAR_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [qct_pkg::CHAR_W-1:0]     line_byte,
	input  logic                           line_last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     result_kind,
	output logic [qct_pkg::CHAR_W-1:0]     token_char,
	output logic [qct_pkg::NUM_W-1:0]      token_number,
	output logic [qct_pkg::LEN_W-1:0]      token_length,
	output logic                           line_status,
	output logic [qct_pkg::LEN_W-1:0]      error_position,
	output logic                           result_last
);

	logic             q_full;
	logic             push;
	logic             pop;
	qct_pkg::bundle_t push_bundle;
	qct_pkg::q_head_t head;

	qct_front #(
		.MAX_LINE_CHARS(MAX_LINE_CHARS),
		.MAX_TOKENS(MAX_TOKENS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.line_byte(line_byte),
		.line_last(line_last),
		.q_full(q_full),
		.push(push),
		.push_bundle(push_bundle)
	);

	qct_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_bundle(push_bundle),
		.full(q_full),
		.pop(pop),
		.head(head)
	);

	qct_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.token_char(token_char),
		.token_number(token_number),
		.token_length(token_length),
		.line_status(line_status),
		.error_position(error_position),
		.result_last(result_last)
	);

endmodule

FILE: tb/sv/tb_quoted_command_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_quoted_command_tokenizer
// Self-checking bench for the streaming shell-style command tokenizer.
// ----------------------------------------------------------------------------
// A scoreboard class predicts every result of each accepted line byte from its
// own copy of the tokenizer state and registers, and checks the results in
// order as they leave the block. Directed lines cover the quoting, escape,
// comment, whitespace and delimiter rules; random lines then run under several
// idle and stall patterns and register settings.
// ----------------------------------------------------------------------------
localparam int LINE_CHAR_CAP = (qct_pkg::DEF_MAX_LINE_CHARS < qct_pkg::LEN_FIELD_MAX) ?
	qct_pkg::DEF_MAX_LINE_CHARS : qct_pkg::LEN_FIELD_MAX;
localparam int TOKEN_CAP = (qct_pkg::DEF_MAX_TOKENS < qct_pkg::NUM_FIELD_MAX) ?
	qct_pkg::DEF_MAX_TOKENS : qct_pkg::NUM_FIELD_MAX;

typedef struct packed {
	qct_pkg::res_t res;
	logic          last;
} token_result_t;

class tokenizer_scoreboard;
	logic [qct_pkg::CHAR_W-1:0] delimiter;
	logic                       normalize;
	bit                         in_quote;
	bit                         escape_pending;
	bit                         comment_seen;
	bit                         pending_space;
	bit                         seen_text;
	int unsigned                token_len;
	int unsigned                token_count;
	int unsigned                char_count;
	token_result_t              expected_q[$];
	int unsigned                fail_count;

	function new();
		delimiter = qct_pkg::DELIM_RESET;
		normalize = qct_pkg::NORM_RESET;
		fail_count = 0;
		clear_line();
	endfunction

	function void clear_line();
		in_quote = 0;
		escape_pending = 0;
		comment_seen = 0;
		pending_space = 0;
		seen_text = 0;
		token_len = 0;
		token_count = 0;
		char_count = 0;
	endfunction

	function void set_register(logic [qct_pkg::CFG_IDX_W-1:0] idx,
			logic [qct_pkg::CHAR_W-1:0] val);
		if (idx == qct_pkg::CFG_DELIM) begin
			delimiter = val;
		end else begin
			normalize = val[0];
		end
	endfunction

	function int unsigned outstanding();
		return expected_q.size();
	endfunction

	function void emit(qct_pkg::kind_t kind, logic [qct_pkg::CHAR_W-1:0] ch,
			int unsigned num, int unsigned len, bit st, int unsigned pos);
		token_result_t e;
		e.res.kind = kind;
		e.res.ch   = ch;
		e.res.num  = qct_pkg::NUM_W'(num);
		e.res.len  = qct_pkg::LEN_W'(len);
		e.res.st   = st;
		e.res.pos  = qct_pkg::LEN_W'(pos);
		e.last     = 1'b0;
		expected_q = {expected_q, e};
	endfunction

	function void append_char(logic [qct_pkg::CHAR_W-1:0] c);
		emit(qct_pkg::KIND_CHAR, c, token_count, 0, 0, 0);
		if (token_len < LINE_CHAR_CAP)
			token_len++;
		escape_pending = 0;
	endfunction

	function void close_token();
		emit(qct_pkg::KIND_TOKEN, '0, token_count, token_len, 0, 0);
		if (token_count < TOKEN_CAP)
			token_count++;
		token_len = 0;
	endfunction

	function void tokenize(logic [qct_pkg::CHAR_W-1:0] c);
		if (comment_seen)
			return;
		if (char_count < LINE_CHAR_CAP)
			char_count++;
		if (in_quote) begin
			if (c == qct_pkg::CH_BSLASH) begin
				if (escape_pending)
					append_char(c);
				else
					escape_pending = 1;
			end else if (c == qct_pkg::CH_QUOTE) begin
				if (escape_pending)
					append_char(c);
				else
					in_quote = 0;
			end else begin
				append_char(c);
			end
		end else if (c == qct_pkg::CH_QUOTE) begin
			in_quote = 1;
		end else if (c == qct_pkg::CH_HASH) begin
			comment_seen = 1;
		end else if (c == delimiter) begin
			close_token();
		end else begin
			append_char(c);
		end
	endfunction

	function void note_byte(logic [qct_pkg::CHAR_W-1:0] b, logic last);
		int unsigned first;
		bit          ws;
		first = expected_q.size();
		ws = (b == qct_pkg::CH_SPACE || b == qct_pkg::CH_TAB || b == qct_pkg::CH_CR ||
			b == qct_pkg::CH_LF);
		if (normalize) begin
			if (ws) begin
				if (seen_text)
					pending_space = 1;
			end else begin
				if (pending_space)
					tokenize(qct_pkg::CH_SPACE);
				pending_space = 0;
				seen_text = 1;
				tokenize(b);
			end
		end else begin
			tokenize(b);
		end
		if (last) begin
			if (token_len > 0)
				close_token();
			emit(qct_pkg::KIND_LINE, '0, token_count, 0, in_quote,
				in_quote ? char_count : 0);
			clear_line();
		end
		if (expected_q.size() > first)
			expected_q[expected_q.size() - 1].last = 1'b1;
	endfunction

	function void check_result(logic [1:0] kind, logic [qct_pkg::CHAR_W-1:0] ch,
			logic [qct_pkg::NUM_W-1:0] num, logic [qct_pkg::LEN_W-1:0] len, logic st,
			logic [qct_pkg::LEN_W-1:0] pos, logic last);
		token_result_t e;
		if (expected_q.size() == 0) begin
			$error("result with no request behind it: result_kind %0d", kind);
			fail_count++;
			return;
		end
		e = expected_q.pop_front();
		if (kind !== e.res.kind) begin
			$error("result_kind: expected %0d, got %0d", e.res.kind, kind);
			fail_count++;
		end
		if (ch !== e.res.ch) begin
			$error("token_char: expected %0d, got %0d", e.res.ch, ch);
			fail_count++;
		end
		if (num !== e.res.num) begin
			$error("token_number: expected %0d, got %0d", e.res.num, num);
			fail_count++;
		end
		if (len !== e.res.len) begin
			$error("token_length: expected %0d, got %0d", e.res.len, len);
			fail_count++;
		end
		if (st !== e.res.st) begin
			$error("line_status: expected %0d, got %0d", e.res.st, st);
			fail_count++;
		end
		if (pos !== e.res.pos) begin
			$error("error_position: expected %0d, got %0d", e.res.pos, pos);
			fail_count++;
		end
		if (last !== e.last) begin
			$error("result_last: expected %0d, got %0d", e.last, last);
			fail_count++;
		end
	endfunction
endclass

module tb_quoted_command_tokenizer;

	localparam int CYCLE_LIMIT    = 300000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int LONG_HOLD      = 300;
	localparam int BYTES_PER_PHASE = 64;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_write = 1'b0;
	logic [qct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [qct_pkg::CHAR_W-1:0]    cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [qct_pkg::CHAR_W-1:0]    line_byte = '0;
	logic                          line_last = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [1:0]                    result_kind;
	logic [qct_pkg::CHAR_W-1:0]    token_char;
	logic [qct_pkg::NUM_W-1:0]     token_number;
	logic [qct_pkg::LEN_W-1:0]     token_length;
	logic                          line_status;
	logic [qct_pkg::LEN_W-1:0]     error_position;
	logic                          result_last;

	tokenizer_scoreboard sb;
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_stall_pct = 0;
	int unsigned         hold_requests = 0;
	int unsigned         hold_served = 0;
	int unsigned         hold_left = 0;
	int unsigned         cycle_count = 0;

	quoted_command_tokenizer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.line_byte     (line_byte),
		.line_last     (line_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.token_char    (token_char),
		.token_number  (token_number),
		.token_length  (token_length),
		.line_status   (line_status),
		.error_position(error_position),
		.result_last   (result_last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Results are checked and out_ready is driven here; a long hold is also served
	// here, so that the sender keeps offering requests while the results back up.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				sb.check_result(result_kind, token_char, token_number, token_length,
					line_status, error_position, result_last);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served <= hold_served + 1;
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [qct_pkg::CHAR_W-1:0] b, input logic last);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		line_byte <= b;
		line_last <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b, last);
	endtask

	task automatic send_text(input string s, input bit end_line);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], end_line && (i == s.len() - 1));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [qct_pkg::CHAR_W-1:0] delim, input logic norm);
		cfg_write <= 1'b1;
		cfg_index <= qct_pkg::CFG_DELIM;
		cfg_data <= delim;
		@(posedge clk);
		cfg_index <= qct_pkg::CFG_NORM;
		cfg_data <= {{(qct_pkg::CHAR_W - 1){1'b0}}, norm};
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_register(qct_pkg::CFG_DELIM, delim);
		sb.set_register(qct_pkg::CFG_NORM, {{(qct_pkg::CHAR_W - 1){1'b0}}, norm});
	endtask

	function automatic logic [qct_pkg::CHAR_W-1:0] pick_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)
			return qct_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E));
		else if (r < 52)
			return sb.delimiter;
		else if (r < 60)
			return qct_pkg::CH_SPACE;
		else if (r < 64) begin
			case ($urandom_range(2))
				0: return qct_pkg::CH_TAB;
				1: return qct_pkg::CH_CR;
				default: return qct_pkg::CH_LF;
			endcase
		end else if (r < 73)
			return qct_pkg::CH_QUOTE;
		else if (r < 82)
			return qct_pkg::CH_BSLASH;
		else if (r < 85)
			return qct_pkg::CH_HASH;
		return qct_pkg::CHAR_W'($urandom_range(255));
	endfunction

	task automatic run_phase(input int unsigned sidle, input int unsigned rstall,
			input logic [qct_pkg::CHAR_W-1:0] delim, input logic norm, input bit long_hold);
		int unsigned sent;
		int unsigned len;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		configure(delim, norm);
		if (long_hold)
			hold_requests++;
		sent = 0;
		while (sent < BYTES_PER_PHASE) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 14);
			for (int i = 0; i < len; i++)
				send_byte(pick_byte(), i == len - 1);
			sent += len;
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: whitespace folding, quoting, escapes and a comment.
		send_text(" \ta", 0);
		send_byte(qct_pkg::CH_CR, 0);
		send_text("\n\"b\\\"\\\\\\q\" c\\d #z ", 1);
		send_byte(8'h00, 0);
		send_byte(8'hFF, 0);
		send_text(" \"\"", 1);
		send_text("\"ab", 1);
		drain();

		// Folding switched off and on again within one line.
		send_text("p\t", 0);
		drain();
		configure(qct_pkg::CH_SPACE, 1'b0);
		send_text(" s", 0);
		drain();
		configure(qct_pkg::CH_SPACE, 1'b1);
		send_text("t", 1);
		drain();

		configure(qct_pkg::CH_SPACE, 1'b0);
		send_text("a  b", 1);
		drain();
		configure(qct_pkg::CH_QUOTE, 1'b0);
		send_text("a\"b c\"", 1);
		drain();
		configure(qct_pkg::CH_BSLASH, 1'b0);
		send_text("a\\b\"c\\\"d\"", 1);
		drain();
		configure(qct_pkg::CH_HASH, 1'b1);
		send_text("a#b", 1);
		drain();

		run_phase(0, 0, qct_pkg::CH_SPACE, 1'b1, 0);
		run_phase(82, 0, 8'h00, 1'b0, 0);
		run_phase(0, 82, 8'hFF, 1'b1, 1);
		run_phase(21, 21, ",", 1'b0, 0);
		run_phase(0, 0, qct_pkg::CH_BSLASH, 1'b1, 1);

		if (sb.fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
